>>> hw/rtl/lru_pkg.sv
// Shared types, sizes and helper functions of the LRU page replacement unit.
package lru_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int PAGE_IN_W  = 16;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int AGE_W      = IDX_W;
    localparam int USED_W     = $clog2(NUM_FRAMES + 1);
    localparam int LIM_W      = (USED_W > CFG_W) ? USED_W : CFG_W;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(4);
    localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [AGE_W-1:0]     age_t;
    typedef logic [USED_W-1:0]    used_t;

    // Table update issued by the sequencer when an item commits.
    typedef struct packed {
        logic  en;
        logic  clear;
        logic  fill;
        idx_t  slot;
        page_t page;
    } upd_t;

    // Running result of the frame scan.
    typedef struct packed {
        logic  hit;
        idx_t  hit_slot;
        logic  free_found;
        idx_t  free_slot;
        used_t used;
        logic  victim_found;
        idx_t  victim_slot;
        age_t  victim_age;
        page_t victim_page;
    } scan_t;

    // Low PAGE_BITS bits of the port value, zero-extended if the page is wider.
    function automatic page_t page_from_in(input logic [PAGE_IN_W-1:0] v);
        page_t r;
        for (int b = 0; b < PAGE_BITS; b++)
        begin
            r[b] = (b < PAGE_IN_W) ? v[b] : 1'b0;
        end
        return r;
    endfunction

    // Low port-width bits of a page number.
    function automatic logic [PAGE_IN_W-1:0] page_to_out(input page_t p);
        logic [PAGE_IN_W-1:0] r;
        for (int b = 0; b < PAGE_IN_W; b++)
        begin
            r[b] = (b < PAGE_BITS) ? p[b] : 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/lru_frame_tbl.sv
// Frame table: resident page numbers, valid bits and recency ranks.
module lru_frame_tbl
(
    input  logic            clk,
    input  logic            rst_n,
    input  lru_pkg::idx_t   rd_idx,
    output lru_pkg::page_t  rd_page,
    output logic            rd_valid,
    output lru_pkg::age_t   rd_age,
    input  lru_pkg::upd_t   upd
);

    lru_pkg::page_t                    page_mem [lru_pkg::NUM_FRAMES];
    logic [lru_pkg::NUM_FRAMES-1:0]    valid_reg;
    logic [lru_pkg::NUM_FRAMES-1:0]    valid_next;
    lru_pkg::age_t                     age_reg  [lru_pkg::NUM_FRAMES];
    lru_pkg::age_t                     age_next [lru_pkg::NUM_FRAMES];
    lru_pkg::age_t                     limit_age;

    assign rd_page  = page_mem[rd_idx];
    assign rd_valid = valid_reg[rd_idx];
    assign rd_age   = age_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            page_mem[upd.slot] <= upd.page;
        end
    end

    // The touched frame becomes most recent; valid frames younger than its old
    // rank age by one, or all valid frames do when a free frame is filled.
    always_comb
    begin
        limit_age = age_reg[upd.slot];
        for (int i = 0; i < lru_pkg::NUM_FRAMES; i++)
        begin
            valid_next[i] = valid_reg[i];
            age_next[i]   = age_reg[i];
            if (upd.en)
            begin
                if (lru_pkg::idx_t'(i) == upd.slot)
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i] && (upd.fill || (age_reg[i] < limit_age)))
                begin
                    age_next[i] = age_reg[i] + lru_pkg::age_t'(1);
                end
            end
            if (upd.clear)
            begin
                valid_next[i] = 1'b0;
                age_next[i]   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < lru_pkg::NUM_FRAMES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < lru_pkg::NUM_FRAMES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

endmodule

>>> hw/rtl/lru_scan_unit.sv
// Shared scan unit: one frame per cycle while step is high, via page and age comparators.
module lru_scan_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            step,
    input  lru_pkg::idx_t   step_idx,
    input  lru_pkg::page_t  ref_page,
    input  lru_pkg::page_t  rd_page,
    input  logic            rd_valid,
    input  lru_pkg::age_t   rd_age,
    output lru_pkg::scan_t  res
);

    lru_pkg::scan_t res_reg;
    lru_pkg::scan_t res_next;
    logic           page_eq;
    logic           age_gt;

    assign page_eq = (rd_page == ref_page);
    assign age_gt  = (rd_age > res_reg.victim_age);
    assign res     = res_reg;

    always_comb
    begin
        res_next = res_reg;
        if (start)
        begin
            res_next = '0;
        end
        else if (step)
        begin
            if (rd_valid)
            begin
                res_next.used = res_reg.used + lru_pkg::used_t'(1);
                if (!res_reg.hit && page_eq)
                begin
                    res_next.hit      = 1'b1;
                    res_next.hit_slot = step_idx;
                end
                // Strictly older wins, so the lowest frame keeps a tie.
                if (!res_reg.victim_found || age_gt)
                begin
                    res_next.victim_found = 1'b1;
                    res_next.victim_slot  = step_idx;
                    res_next.victim_age   = rd_age;
                    res_next.victim_page  = rd_page;
                end
            end
            else if (!res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_slot  = step_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hw/rtl/lru_page_replacement_unit.sv
// An accepted reference is scanned one frame per cycle through the shared comparators,
// then commits, and the result is registered onto m_tvalid and m_tdata.
// The block takes no new reference while a scan or commit is in progress, and a result
// still waiting for m_tready holds the commit back.
// Reset empties the frame table, clears the fault count and sets frame_count to 4.
module lru_page_replacement_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,    // frame_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] page_number
    input  logic        s_tlast,     // last_ref
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata      // [0] fault, [1] evicted_valid, [17:2] evicted_page,
                                     // [33:18] fault_count, [39:34] zero
);

    localparam int OUT_W = 40;
    localparam int PAD_W = OUT_W - (2 + lru_pkg::PAGE_IN_W + lru_pkg::CNT_W);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

    state_t                          state_reg, state_next;
    lru_pkg::idx_t                   idx_reg, idx_next;
    lru_pkg::page_t                  page_reg, page_next;
    logic                            last_reg, last_next;
    logic [lru_pkg::CNT_W-1:0]       fault_cnt_reg, fault_cnt_next;
    logic [lru_pkg::CFG_W-1:0]       frame_count_reg, frame_count_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]                m_tdata_reg, m_tdata_next;

    logic                            in_fire;
    logic                            commit_fire;
    logic                            miss;
    logic                            do_fill;
    logic                            do_repl;
    logic [lru_pkg::LIM_W-1:0]       cfg_ext;
    logic [lru_pkg::LIM_W-1:0]       limit;
    logic [lru_pkg::CNT_W-1:0]       cnt_new;
    logic [lru_pkg::PAGE_IN_W-1:0]   ev_page;

    lru_pkg::upd_t                   upd;
    lru_pkg::scan_t                  scan;
    lru_pkg::page_t                  rd_page;
    logic                            rd_valid;
    lru_pkg::age_t                   rd_age;

    lru_frame_tbl u_tbl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_page  (rd_page),
        .rd_valid (rd_valid),
        .rd_age   (rd_age),
        .upd      (upd)
    );

    lru_scan_unit u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .step     (state_reg == ST_SCAN),
        .step_idx (idx_reg),
        .ref_page (page_reg),
        .rd_page  (rd_page),
        .rd_valid (rd_valid),
        .rd_age   (rd_age),
        .res      (scan)
    );

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign in_fire     = s_tvalid && s_tready;
    assign commit_fire = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);

    // Active frame count: zero acts as one, anything above the built count saturates.
    always_comb
    begin
        cfg_ext = lru_pkg::LIM_W'(frame_count_reg);
        if (cfg_ext == '0)
        begin
            limit = lru_pkg::LIM_W'(1);
        end
        else if (cfg_ext > lru_pkg::LIM_W'(lru_pkg::NUM_FRAMES))
        begin
            limit = lru_pkg::LIM_W'(lru_pkg::NUM_FRAMES);
        end
        else
        begin
            limit = cfg_ext;
        end
    end

    always_comb
    begin
        miss    = !scan.hit;
        do_fill = miss && scan.free_found && (lru_pkg::LIM_W'(scan.used) < limit);
        do_repl = miss && !do_fill && scan.victim_found;
        cnt_new = (miss && (fault_cnt_reg != lru_pkg::COUNT_MAX))
                  ? fault_cnt_reg + lru_pkg::CNT_W'(1) : fault_cnt_reg;
        ev_page = do_repl ? lru_pkg::page_to_out(scan.victim_page) : '0;

        upd.en    = commit_fire && (!miss || do_fill || do_repl);
        upd.clear = commit_fire && last_reg;
        upd.fill  = do_fill;
        upd.page  = page_reg;
        if (!miss)
        begin
            upd.slot = scan.hit_slot;
        end
        else if (do_fill)
        begin
            upd.slot = scan.free_slot;
        end
        else
        begin
            upd.slot = scan.victim_slot;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        page_next        = page_reg;
        last_next        = last_reg;
        fault_cnt_next   = fault_cnt_reg;
        frame_count_next = frame_count_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (cfg_valid && cfg_ready)
        begin
            frame_count_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    page_next  = lru_pkg::page_from_in(s_tdata);
                    last_next  = s_tlast;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == lru_pkg::idx_t'(lru_pkg::NUM_FRAMES - 1))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    idx_next = idx_reg + lru_pkg::idx_t'(1);
                end
            end
            ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {{PAD_W{1'b0}}, cnt_new, ev_page, do_repl, miss};
                    fault_cnt_next = last_reg ? '0 : cnt_new;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            last_reg        <= 1'b0;
            fault_cnt_reg   <= '0;
            frame_count_reg <= lru_pkg::FRAME_COUNT_RST;
            m_tvalid_reg    <= 1'b0;
            page_reg        <= '0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            last_reg        <= last_next;
            fault_cnt_reg   <= fault_cnt_next;
            frame_count_reg <= frame_count_next;
            m_tvalid_reg    <= m_tvalid_next;
            page_reg        <= page_next;
            m_tdata_reg     <= m_tdata_next;
        end
    end

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SCAN))
        else $error("accepted reference did not start a scan");

    a_evict_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
        else $error("eviction reported on a hit");

    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_fire && last_reg) |=> (fault_cnt_reg == '0))
        else $error("fault count not cleared after last reference");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit_fire && last_reg) |=> (fault_cnt_reg >= $past(fault_cnt_reg)))
        else $error("fault count decreased within a run");

endmodule
